// ----- hdl/sensor_min_max_block_average_macros.svh -----
// Assertion macros for the sensor min/max block average checker.
// Include this file by bare name; it depends on nothing else.
`ifndef SENSOR_MIN_MAX_BLOCK_AVERAGE_MACROS_SVH
`define SENSOR_MIN_MAX_BLOCK_AVERAGE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SMMBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SMMBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/smmba_pkg.sv -----
// Shared types and constants for the sensor min/max block average.
// No dependencies; compiled before every other file.
package smmba_pkg;

   localparam int GAS_W       = 16;
   localparam int TEMP_W      = 12;
   localparam int HUMIN_W     = 10;
   localparam int HUMID_W     = 7;
   localparam int SLOT_W      = 5;
   localparam int BYTE_W      = 8;
   localparam int POS_W       = 9;
   localparam int ACC_W       = 13;
   localparam int RECENT_DEPTH = 32;

   localparam logic [GAS_W-1:0]         GAS_MIN_RESET   = 16'd5000;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN_RESET  = 12'sd1000;
   localparam logic [HUMID_W-1:0]       HUMID_MIN_RESET = 7'd100;

   // divide by ten as multiply by 205 then shift right by 11, exact below 1024
   localparam logic [7:0] HUMID_RECIP = 8'd205;
   localparam int         HUMID_SHIFT = 11;
   localparam int         HUMID_PROD_W = HUMIN_W + 8;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RECENT_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUM,
      ST_EMIT
   } smmba_state_type;

   typedef struct packed {
      logic load_in;
      logic update;
      logic sum_step;
      logic emit;
   } smmba_cmd_type;

   typedef struct packed {
      logic slot_zero;
      logic sum_last;
      logic out_free;
   } smmba_stat_type;

endpackage

// ----- hdl/smmba_if.sv -----
// Handshake channels for readings in and results out.
// Depends on smmba_pkg for field widths.
interface smmba_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [smmba_pkg::SLOT_W-1:0]             sample_slot;
   logic [smmba_pkg::GAS_W-1:0]              gas_ppm;
   logic signed [smmba_pkg::TEMP_W-1:0]      temperature;
   logic [smmba_pkg::HUMIN_W-1:0]            humidity;

   modport source (output valid, sample_slot, gas_ppm, temperature, humidity, input ready);
   modport sink   (input valid, sample_slot, gas_ppm, temperature, humidity, output ready);
endinterface

interface smmba_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [smmba_pkg::GAS_W-1:0]              gas_max;
   logic [smmba_pkg::GAS_W-1:0]              gas_min;
   logic signed [smmba_pkg::TEMP_W-1:0]      temp_max;
   logic signed [smmba_pkg::TEMP_W-1:0]      temp_min;
   logic [smmba_pkg::HUMID_W-1:0]            humid_max;
   logic [smmba_pkg::HUMID_W-1:0]            humid_min;
   logic                                     average_valid;
   logic [smmba_pkg::BYTE_W-1:0]             average_value;
   logic [smmba_pkg::POS_W-1:0]              history_position;

   modport source (output valid, gas_max, gas_min, temp_max, temp_min, humid_max, humid_min,
                   average_valid, average_value, history_position, input ready);
   modport sink   (input valid, gas_max, gas_min, temp_max, temp_min, humid_max, humid_min,
                   average_valid, average_value, history_position, output ready);
endinterface

// ----- hdl/smmba_ctrl.sv -----
// Sequencer: accepts a word, runs the update, the optional 32-step sum and the emit.
// Depends on smmba_pkg.
module smmba_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  smmba_pkg::smmba_stat_type stat,
   output smmba_pkg::smmba_cmd_type  cmd
);
   import smmba_pkg::*;

   smmba_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // no word is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load_in = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.update = 1'b1;
            state_in   = stat.slot_zero ? ST_SUM : ST_EMIT;
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (stat.sum_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // wait until the output register can take the word
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- hdl/smmba_dp.sv -----
// Datapath: min/max registers, recent store with serial sum, history and output register.
// Depends on smmba_pkg; driven by smmba_ctrl commands.
module smmba_dp #(
   parameter int HISTORY_DEPTH = 512
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  smmba_pkg::smmba_cmd_type             cmd,
   output smmba_pkg::smmba_stat_type            stat,
   input  logic [smmba_pkg::SLOT_W-1:0]         in_slot,
   input  logic [smmba_pkg::GAS_W-1:0]          in_gas,
   input  logic signed [smmba_pkg::TEMP_W-1:0]  in_temp,
   input  logic [smmba_pkg::HUMIN_W-1:0]        in_humid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [smmba_pkg::GAS_W-1:0]          rsp_gas_max,
   output logic [smmba_pkg::GAS_W-1:0]          rsp_gas_min,
   output logic signed [smmba_pkg::TEMP_W-1:0]  rsp_temp_max,
   output logic signed [smmba_pkg::TEMP_W-1:0]  rsp_temp_min,
   output logic [smmba_pkg::HUMID_W-1:0]        rsp_humid_max,
   output logic [smmba_pkg::HUMID_W-1:0]        rsp_humid_min,
   output logic                                 rsp_avg_valid,
   output logic [smmba_pkg::BYTE_W-1:0]         rsp_avg_value,
   output logic [smmba_pkg::POS_W-1:0]          rsp_position
);
   import smmba_pkg::*;

   localparam int HEAD_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(HISTORY_DEPTH - 1);

   // captured input word
   logic [SLOT_W-1:0]         slot_ff;
   logic [GAS_W-1:0]          gas_ff;
   logic signed [TEMP_W-1:0]  temp_ff;
   logic [HUMIN_W-1:0]        humid_ff;

   // running extremes
   logic [GAS_W-1:0]          max_gas_ff, min_gas_ff;
   logic signed [TEMP_W-1:0]  max_temp_ff, min_temp_ff;
   logic [HUMID_W-1:0]        max_humid_ff, min_humid_ff;

   logic [BYTE_W-1:0]         recent_ff [RECENT_DEPTH];
   logic [SLOT_W-1:0]         sum_cnt_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic [HEAD_W-1:0]         head_ff;
   logic [BYTE_W-1:0]         hist_mem [HISTORY_DEPTH];

   logic [HUMID_PROD_W-1:0]   humid_prod;
   logic [HUMID_W-1:0]        humid_pct;
   logic [BYTE_W-1:0]         avg_byte;
   logic [HEAD_W+POS_W-1:0]   head_wide;
   logic                      out_valid_ff;

   assign humid_prod = HUMID_PROD_W'(humid_ff) * HUMID_PROD_W'(HUMID_RECIP);
   assign humid_pct  = humid_prod[HUMID_PROD_W-1:HUMID_SHIFT];
   assign avg_byte   = acc_ff[ACC_W-1:SLOT_W];
   assign head_wide  = (HEAD_W+POS_W)'(head_ff);

   assign stat.slot_zero = (slot_ff == '0);
   assign stat.sum_last  = (sum_cnt_ff == SLOT_LAST);
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         slot_ff  <= in_slot;
         gas_ff   <= in_gas;
         temp_ff  <= in_temp;
         humid_ff <= in_humid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_gas_ff   <= '0;
         min_gas_ff   <= GAS_MIN_RESET;
         max_temp_ff  <= '0;
         min_temp_ff  <= TEMP_MIN_RESET;
         max_humid_ff <= '0;
         min_humid_ff <= HUMID_MIN_RESET;
         for (int i = 0; i < RECENT_DEPTH; i++) begin
            recent_ff[i] <= '0;
         end
      end else if (cmd.update) begin
         if (gas_ff > max_gas_ff)      max_gas_ff   <= gas_ff;
         if (gas_ff < min_gas_ff)      min_gas_ff   <= gas_ff;
         if (temp_ff > max_temp_ff)    max_temp_ff  <= temp_ff;
         if (temp_ff < min_temp_ff)    min_temp_ff  <= temp_ff;
         if (humid_pct > max_humid_ff) max_humid_ff <= humid_pct;
         if (humid_pct < min_humid_ff) min_humid_ff <= humid_pct;
         recent_ff[slot_ff] <= gas_ff[BYTE_W+SLOT_W-1:SLOT_W];
      end
   end

   // one entry per cycle; the update cycle has already stored this word's byte
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         sum_cnt_ff <= '0;
         acc_ff     <= '0;
      end else if (cmd.sum_step) begin
         sum_cnt_ff <= sum_cnt_ff + 1'b1;
         acc_ff     <= acc_ff + ACC_W'(recent_ff[sum_cnt_ff]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else if (cmd.emit && stat.slot_zero) begin
         head_ff <= (head_ff == HEAD_LAST) ? '0 : head_ff + 1'b1;
      end
   end

   // history write port only; nothing in this block reads it back
   always_ff @(posedge clock) begin
      if (cmd.emit && stat.slot_zero) begin
         hist_mem[head_ff] <= avg_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_gas_max   <= max_gas_ff;
         rsp_gas_min   <= min_gas_ff;
         rsp_temp_max  <= max_temp_ff;
         rsp_temp_min  <= min_temp_ff;
         rsp_humid_max <= max_humid_ff;
         rsp_humid_min <= min_humid_ff;
         rsp_avg_valid <= stat.slot_zero;
         rsp_avg_value <= stat.slot_zero ? avg_byte : '0;
         rsp_position  <= stat.slot_zero ? head_wide[POS_W-1:0] : '0;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

// ----- hdl/sensor_min_max_block_average.sv -----
// Sensor min/max tracker with gas block average.
// Channels: req_chan (sink) takes one reading word: slot, gas, temperature,
// humidity. rsp_chan (source) returns one result word per reading with the
// running extremes and, for slot 0, the block average and its history slot.
// Steps: a nonzero-slot word passes from the accept through the load state
// to the emit state; a slot-0 word also passes the sum state, since the
// 32-entry recent store is summed through one adder, one entry per cycle.
// One word at a time: the next word is taken once the result is in the
// output register.
// A finished result waits in the output register while the next word is
// accepted and processed; if the receiver stalls, that next result waits in
// its last step until the register frees, and req_chan.ready stays low.
// Reset: extremes return to their start values (gas min 5000, temperature
// min 100.0 degrees, humidity min 100 percent, maxima zero), the recent
// store clears in the reset cycle, history head returns to slot 0. History
// contents are not cleared.
// Depends on smmba_pkg, smmba_if, smmba_ctrl, smmba_dp.
module sensor_min_max_block_average #(
   parameter int HISTORY_DEPTH = 512
) (
   input  logic       clock,
   input  logic       reset,
   smmba_req_if.sink   req_chan,
   smmba_rsp_if.source rsp_chan
);
   import smmba_pkg::*;

   smmba_cmd_type  cmd;
   smmba_stat_type stat;

   smmba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   smmba_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .in_slot       (req_chan.sample_slot),
      .in_gas        (req_chan.gas_ppm),
      .in_temp       (req_chan.temperature),
      .in_humid      (req_chan.humidity),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_gas_max   (rsp_chan.gas_max),
      .rsp_gas_min   (rsp_chan.gas_min),
      .rsp_temp_max  (rsp_chan.temp_max),
      .rsp_temp_min  (rsp_chan.temp_min),
      .rsp_humid_max (rsp_chan.humid_max),
      .rsp_humid_min (rsp_chan.humid_min),
      .rsp_avg_valid (rsp_chan.average_valid),
      .rsp_avg_value (rsp_chan.average_value),
      .rsp_position  (rsp_chan.history_position)
   );

endmodule

// ----- hdl/smmba_checker.sv -----
// Port-level checks for sensor_min_max_block_average, bound to the top level.
// Depends on smmba_pkg and the assertion macro header.
`include "sensor_min_max_block_average_macros.svh"

module smmba_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [smmba_pkg::GAS_W-1:0]          gas_max,
   input logic [smmba_pkg::GAS_W-1:0]          gas_min,
   input logic signed [smmba_pkg::TEMP_W-1:0]  temp_max,
   input logic signed [smmba_pkg::TEMP_W-1:0]  temp_min,
   input logic [smmba_pkg::HUMID_W-1:0]        humid_max,
   input logic [smmba_pkg::HUMID_W-1:0]        humid_min,
   input logic                                 average_valid,
   input logic [smmba_pkg::BYTE_W-1:0]         average_value,
   input logic [smmba_pkg::POS_W-1:0]          history_position
);
   import smmba_pkg::*;

   // every reported word follows at least one reading, so max never drops below min
   `SMMBA_ASSERT_NOW(a_extremes_ordered, clock, reset, rsp_valid, (gas_max >= gas_min) && (temp_max >= temp_min) && (humid_max >= humid_min), "max below min in result word")

   `SMMBA_ASSERT_NOW(a_no_avg_zero, clock, reset, rsp_valid && !average_valid, (average_value == '0) && (history_position == '0), "average fields nonzero without average")

   // one reading in flight: busy right after an accept
   `SMMBA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "accepted back-to-back readings")

   `SMMBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(gas_max) && $stable(average_value) && $stable(history_position), "stalled result word changed")

endmodule

bind sensor_min_max_block_average smmba_checker u_smmba_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .gas_max          (rsp_chan.gas_max),
   .gas_min          (rsp_chan.gas_min),
   .temp_max         (rsp_chan.temp_max),
   .temp_min         (rsp_chan.temp_min),
   .humid_max        (rsp_chan.humid_max),
   .humid_min        (rsp_chan.humid_min),
   .average_valid    (rsp_chan.average_valid),
   .average_value    (rsp_chan.average_value),
   .history_position (rsp_chan.history_position)
);

// ----- sim/tb_top.sv -----
// Testbench for sensor_min_max_block_average: directed readings, then random counting runs,
// slot-0 bursts and noise, each result word checked against an in-bench tracker or a scripted value.
// Depends on hdl/smmba_pkg.sv, hdl/smmba_if.sv and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
   import smmba_pkg::*;

   localparam int HIST_DEPTH   = 512;
   localparam int IDLE_PCT     = 36;
   localparam int RANDOM_WORDS = 800;
   localparam int DRAIN_CYCLES = 40;
   localparam int LIMIT_CYCLES = 400000;

   typedef struct packed {
      logic [SLOT_W-1:0]         slot;
      logic [GAS_W-1:0]          gas;
      logic signed [TEMP_W-1:0]  temp;
      logic [HUMIN_W-1:0]        hum;
   } reading_t;

   typedef struct packed {
      logic [GAS_W-1:0]          gas_max;
      logic [GAS_W-1:0]          gas_min;
      logic signed [TEMP_W-1:0]  temp_max;
      logic signed [TEMP_W-1:0]  temp_min;
      logic [HUMID_W-1:0]        humid_max;
      logic [HUMID_W-1:0]        humid_min;
      logic                      avg_valid;
      logic [BYTE_W-1:0]         avg_value;
      logic [POS_W-1:0]          hist_pos;
   } summary_t;

   typedef struct {
      reading_t rd;
      bit       typed;
      summary_t want;
   } script_row_t;

   logic clock;
   logic reset;

   smmba_req_if req_chan ();
   smmba_rsp_if rsp_chan ();

   sensor_min_max_block_average u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // tracker state
   logic [GAS_W-1:0]          gas_hi, gas_lo;
   logic signed [TEMP_W-1:0]  temp_hi, temp_lo;
   logic [HUMID_W-1:0]        hum_hi, hum_lo;
   logic [BYTE_W-1:0]         recent_gas [RECENT_DEPTH];
   int                        hist_head;
   bit                        head_wrapped;

   summary_t     expected_summaries [$];
   script_row_t  script [$];
   int           fail_count;
   int           cycle_count;
   bit           quiet;
   summary_t     want_word;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic fold_reading(input reading_t rd, output summary_t res);
      logic [ACC_W-1:0]   sum;
      logic [HUMID_W-1:0] pct;
      pct = HUMID_W'(rd.hum / 10);
      res = '0;
      if (rd.gas > gas_hi) gas_hi = rd.gas;
      if (rd.gas < gas_lo) gas_lo = rd.gas;
      recent_gas[rd.slot] = rd.gas[12:5];
      if (rd.slot == 0) begin
         sum = '0;
         for (int k = 0; k < RECENT_DEPTH; k++) sum += recent_gas[k];
         res.avg_valid = 1'b1;
         res.avg_value = BYTE_W'(sum >> 5);
         res.hist_pos  = POS_W'(hist_head);
         hist_head++;
         if (hist_head >= HIST_DEPTH) begin
            hist_head    = 0;
            head_wrapped = 1'b1;
         end
      end
      if (rd.temp > temp_hi) temp_hi = rd.temp;
      if (rd.temp < temp_lo) temp_lo = rd.temp;
      if (pct > hum_hi) hum_hi = pct;
      if (pct < hum_lo) hum_lo = pct;
      res.gas_max   = gas_hi;
      res.gas_min   = gas_lo;
      res.temp_max  = temp_hi;
      res.temp_min  = temp_lo;
      res.humid_max = hum_hi;
      res.humid_min = hum_lo;
   endtask

   task automatic add_row(input int slot, input int gas, input int temp, input int hum,
                          input bit typed, input summary_t want);
      script_row_t row;
      row.rd    = '{slot: SLOT_W'(slot), gas: GAS_W'(gas), temp: TEMP_W'(temp),
                    hum: HUMIN_W'(hum)};
      row.typed = typed;
      row.want  = want;
      script.push_back(row);
   endtask

   // drives one word, waits for acceptance, queues what it should produce
   task automatic push_reading(input reading_t rd, input bit typed, input summary_t want);
      summary_t got;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.sample_slot <= rd.slot;
      req_chan.gas_ppm     <= rd.gas;
      req_chan.temperature <= rd.temp;
      req_chan.humidity    <= rd.hum;
      do @(posedge clock); while (!req_chan.ready);
      fold_reading(rd, got);
      expected_summaries.push_back(typed ? want : got);
   endtask

   function automatic reading_t draw_reading(input logic [SLOT_W-1:0] slot);
      reading_t rd;
      int pick;
      rd.slot = slot;
      pick = $urandom_range(99);
      if (pick < 50)
         rd.gas = GAS_W'($urandom_range(40000));
      else if (pick < 85)
         rd.gas = GAS_W'($urandom);
      else
         case ($urandom_range(4))
            0: rd.gas = 16'd0;
            1: rd.gas = 16'd8191;
            2: rd.gas = 16'd40000;
            3: rd.gas = 16'hFFFF;
            default: rd.gas = 16'h1FE0;
         endcase
      if ($urandom_range(99) < 60)
         rd.temp = TEMP_W'(int'($urandom_range(1650)) - 400);
      else
         rd.temp = TEMP_W'($urandom);
      if ($urandom_range(99) < 70)
         rd.hum = HUMIN_W'($urandom_range(1000));
      else
         rd.hum = HUMIN_W'($urandom_range(1023));
      return rd;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_summaries.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            want_word = expected_summaries.pop_front();
            check_field("gas_max", want_word.gas_max, rsp_chan.gas_max);
            check_field("gas_min", want_word.gas_min, rsp_chan.gas_min);
            check_field("temp_max", int'($signed(want_word.temp_max)),
                        int'($signed(rsp_chan.temp_max)));
            check_field("temp_min", int'($signed(want_word.temp_min)),
                        int'($signed(rsp_chan.temp_min)));
            check_field("humid_max", want_word.humid_max, rsp_chan.humid_max);
            check_field("humid_min", want_word.humid_min, rsp_chan.humid_min);
            check_field("average_valid", want_word.avg_valid, rsp_chan.average_valid);
            check_field("average_value", want_word.avg_value, rsp_chan.average_value);
            check_field("history_position", want_word.hist_pos, rsp_chan.history_position);
         end
      end
      rsp_chan.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int          n_rand;
      int          mode;
      int          len;
      logic [SLOT_W-1:0] slot;
      bit          fixed_gas;
      logic [GAS_W-1:0]  run_gas;
      reading_t    rd;

      quiet        = 1'b0;
      n_rand       = 0;
      gas_hi       = '0;
      gas_lo       = GAS_MIN_RESET;
      temp_hi      = '0;
      temp_lo      = TEMP_MIN_RESET;
      hum_hi       = '0;
      hum_lo       = HUMID_MIN_RESET;
      hist_head    = 0;
      head_wrapped = 1'b0;
      for (int k = 0; k < RECENT_DEPTH; k++) recent_gas[k] = '0;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.sample_slot <= '0;
      req_chan.gas_ppm     <= '0;
      req_chan.temperature <= '0;
      req_chan.humidity    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // first word after reset moves both min and max of every quantity
      add_row(3, 1000, 250, 455, 1'b1, '{16'd1000, 16'd1000, 12'sd250, 12'sd250,
                                          7'd45, 7'd45, 1'b0, 8'd0, 9'd0});
      // slot 0 with an almost empty store: average 0 at history slot 0
      add_row(0, 0, 0, 0, 1'b1, '{16'd1000, 16'd0, 12'sd250, 12'sd0,
                                   7'd45, 7'd0, 1'b1, 8'd0, 9'd0});
      add_row(0, 40000, 1250, 1000, 1'b0, '0);
      add_row(31, 8191, -400, 999, 1'b0, '0);
      add_row(0, 5000, 100, 500, 1'b0, '0);
      // out-of-range readings compared at field width
      add_row(17, 65535, 2047, 1023, 1'b0, '0);
      add_row(0, 8160, -2048, 9, 1'b0, '0);
      add_row(1, 40000, 0, 10, 1'b0, '0);
      add_row(30, 12345, -1, 0, 1'b0, '0);
      add_row(0, 65535, 1250, 1023, 1'b0, '0);
      add_row(16, 0, -400, 0, 1'b0, '0);
      add_row(8, 'h1234, 'h555, 'h2AA, 1'b0, '0);
      add_row(21, 'hEDCB, -1366, 'h155, 1'b0, '0);
      add_row(0, 31, 5, 5, 1'b0, '0);

      foreach (script[i]) push_reading(script[i].rd, script[i].typed, script[i].want);

      // keep going until the history head has wrapped at least once
      while (n_rand < RANDOM_WORDS || !head_wrapped) begin
         mode = $urandom_range(99);
         if (mode < 25) begin
            // caller's sample counter: consecutive slots
            slot      = SLOT_W'($urandom);
            len       = $urandom_range(1, 32);
            fixed_gas = $urandom_range(1);
            run_gas   = ($urandom_range(1) != 0) ? 16'hFFFF : GAS_W'($urandom);
         end else if (mode < 92) begin
            slot = '0;
            len  = $urandom_range(1, 24);
            fixed_gas = 1'b0;
         end else begin
            len = $urandom_range(1, 10);
            fixed_gas = 1'b0;
         end
         for (int j = 0; j < len; j++) begin
            if (mode >= 92) slot = SLOT_W'($urandom);
            rd = draw_reading(slot);
            if (fixed_gas) rd.gas = run_gas;
            quiet = (n_rand >= 250 && n_rand < 400);
            push_reading(rd, 1'b0, '0);
            n_rand++;
            if (mode < 25) slot = slot + 1'b1;
         end
      end
      quiet = 1'b0;
      req_chan.valid <= 1'b0;

      while (expected_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
